[rtl/pale_pkg.sv]
// ============================================================================
// pale_pkg
// Types and codes shared by the positional array list engine.
// ============================================================================
package pale_pkg;

    localparam int ValueW = 32;
    localparam int PosInW = 6;
    localparam int PosOutW = 5;
    localparam int CountOutW = 6;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_UPDATE = 3'd2,
        KIND_SEARCH = 3'd3,
        KIND_DUMP   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_TAIL,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [ValueW-1:0] value;
        logic [PosInW-1:0]        position;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [PosOutW-1:0]       found_position;
        logic signed [ValueW-1:0] entry_value;
        logic [CountOutW-1:0]     entry_count;
        logic                     last;
    } res_t;

endpackage

[rtl/pale_chan_if.sv]
// ============================================================================
// pale_chan_if
// Valid/ready channel carrying one item of type T.
// ============================================================================
interface pale_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/positional_array_list_engine_unit.sv]
// ============================================================================
// positional_array_list_engine_unit
// Ordered table of signed words in one synchronous RAM with a fill count.
// Insert/delete: move entries through the RAM (one moved entry per cycle), then
//   insert writes the value, delete lowers the fill count; update only writes.
//   Errors touch no entry. Search/dump: scan every filled entry, held by output
//   stalls. Next request accepted the cycle after the last item is issued.
// Reset: fill count = INIT_COUNT (clamped to DEPTH); per-entry written bits
//   cleared, so an unwritten entry reads as its reset value.
// ============================================================================
module positional_array_list_engine_unit #(
    parameter int DEPTH      = 32,
    parameter int INIT_COUNT = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    pale_chan_if.sink    req,
    pale_chan_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > pale_pkg::PosInW) ? CW : pale_pkg::PosInW;
    localparam int InitFill = (INIT_COUNT > DEPTH) ? DEPTH : INIT_COUNT;
    localparam int VW = pale_pkg::ValueW;

    // table storage
    logic [VW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [VW-1:0]    rdata_reg;
    logic [AW-1:0]    rd_addr_q;
    logic             rd_written_q;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [VW-1:0]    wr_data, rdata_eff;

    pale_pkg::state_t  state_reg, state_next;
    pale_pkg::kind_t   op_reg, op_next;
    pale_pkg::status_t status_reg, status_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [VW-1:0]     val_reg, val_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     wr_idx_reg, wr_idx_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic              pend_reg, pend_next;
    logic              cap_reg, cap_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [AW-1:0]     hold_pos_reg, hold_pos_next;
    logic [VW-1:0]     hold_val_reg, hold_val_next;
    logic              out_valid_reg, out_valid_next;
    pale_pkg::res_t    out_data_reg, out_data_next;

    logic              accept, slot_free, push, hit, stall;
    logic [KW-1:0]     pos_k, fill_k, hold_pos_k;
    pale_pkg::res_t    push_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            rd_addr_q    <= rd_addr;
            rd_written_q <= written_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        if (rd_written_q)
        begin
            rdata_eff = rdata_reg;
        end
        else if (32'(rd_addr_q) < InitFill)
        begin
            rdata_eff = VW'(rd_addr_q);
        end
        else
        begin
            rdata_eff = '0;
        end
    end

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == pale_pkg::S_IDLE);
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign pos_k      = KW'(req.data.position);
    assign fill_k     = KW'(fill_reg);
    assign hold_pos_k = KW'(hold_pos_reg);
    assign hit        = (op_reg == pale_pkg::KIND_DUMP) || (rdata_eff == val_reg);
    assign stall      = pend_reg && hit && hold_valid_reg && !slot_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.data.kind)
                        pale_pkg::KIND_INSERT:
                        begin
                            if (fill_reg == CW'(DEPTH) || pos_k > fill_k)
                            begin
                                state_next = pale_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = pale_pkg::S_SHIFT;
                            end
                        end
                        pale_pkg::KIND_DELETE, pale_pkg::KIND_UPDATE:
                        begin
                            if (fill_reg == '0 || pos_k >= fill_k)
                            begin
                                state_next = pale_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = pale_pkg::S_SHIFT;
                            end
                        end
                        pale_pkg::KIND_SEARCH, pale_pkg::KIND_DUMP:
                        begin
                            state_next = pale_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = pale_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            pale_pkg::S_SHIFT:
            begin
                if (rem_reg == '0 && !pend_reg)
                begin
                    state_next = pale_pkg::S_TAIL;
                end
            end
            pale_pkg::S_TAIL:
            begin
                state_next = pale_pkg::S_RESP;
            end
            pale_pkg::S_SCAN:
            begin
                if (rem_reg == '0 && !pend_reg)
                begin
                    state_next = pale_pkg::S_RESP;
                end
            end
            pale_pkg::S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = pale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pale_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next         = op_reg;
        status_next     = status_reg;
        fill_next       = fill_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        cap_next        = cap_reg;
        hold_valid_next = hold_valid_reg;
        hold_pos_next   = hold_pos_reg;
        hold_val_next   = hold_val_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = wr_idx_reg;
        wr_data         = rdata_eff;
        push            = 1'b0;
        push_data       = '0;

        case (state_reg)
            pale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    val_next        = req.data.value;
                    pos_next        = AW'(req.data.position);
                    hold_pos_next   = AW'(req.data.position);
                    hold_val_next   = req.data.value;
                    hold_valid_next = 1'b0;
                    pend_next       = 1'b0;
                    cap_next        = 1'b0;
                    rem_next        = '0;
                    case (req.data.kind)
                        pale_pkg::KIND_INSERT:
                        begin
                            op_next = pale_pkg::KIND_INSERT;
                            if (fill_reg == CW'(DEPTH))
                            begin
                                status_next = pale_pkg::ST_FULL;
                            end
                            else if (pos_k > fill_k)
                            begin
                                status_next = pale_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                hold_valid_next = 1'b1;
                                rd_idx_next     = AW'(fill_reg - 1'b1);
                                rem_next        = CW'(fill_k - pos_k);
                            end
                        end
                        pale_pkg::KIND_DELETE, pale_pkg::KIND_UPDATE:
                        begin
                            op_next = pale_pkg::kind_t'(req.data.kind);
                            if (fill_reg == '0)
                            begin
                                status_next = pale_pkg::ST_NONE;
                            end
                            else if (pos_k >= fill_k)
                            begin
                                status_next = pale_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                hold_valid_next = 1'b1;
                                rd_idx_next     = AW'(req.data.position);
                                if (req.data.kind == pale_pkg::KIND_DELETE)
                                begin
                                    rem_next = CW'(fill_k - pos_k);
                                end
                            end
                        end
                        pale_pkg::KIND_SEARCH, pale_pkg::KIND_DUMP:
                        begin
                            op_next     = pale_pkg::kind_t'(req.data.kind);
                            status_next = pale_pkg::ST_NONE;
                            rd_idx_next = '0;
                            rem_next    = fill_reg;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                end
            end
            pale_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    if (cap_reg)
                    begin
                        hold_val_next = rdata_eff;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                if (rem_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    pend_next = 1'b1;
                    if (op_reg == pale_pkg::KIND_INSERT)
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        wr_idx_next = rd_idx_reg + 1'b1;
                        cap_next    = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        wr_idx_next = rd_idx_reg - 1'b1;
                        cap_next    = (rd_idx_reg == pos_reg);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            pale_pkg::S_TAIL:
            begin
                wr_addr = pos_reg;
                wr_data = val_reg;
                case (op_reg)
                    pale_pkg::KIND_INSERT:
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    pale_pkg::KIND_UPDATE:
                    begin
                        wr_en = 1'b1;
                    end
                    pale_pkg::KIND_DELETE:
                    begin
                        fill_next = fill_reg - 1'b1;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            pale_pkg::S_SCAN:
            begin
                push_data.status         = pale_pkg::ST_OK;
                push_data.found_position = hold_pos_k[pale_pkg::PosOutW-1:0];
                push_data.entry_value    = hold_val_reg;
                push_data.entry_count    = fill_k[pale_pkg::CountOutW-1:0];
                push_data.last           = 1'b0;
                if (!stall)
                begin
                    if (pend_reg && hit)
                    begin
                        push            = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_pos_next   = wr_idx_reg;
                        hold_val_next   = rdata_eff;
                    end
                    if (rem_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                        wr_idx_next = rd_idx_reg;
                        rem_next    = rem_reg - 1'b1;
                        pend_next   = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            pale_pkg::S_RESP:
            begin
                push_data.entry_count = fill_k[pale_pkg::CountOutW-1:0];
                push_data.last        = 1'b1;
                if (hold_valid_reg)
                begin
                    push_data.status         = pale_pkg::ST_OK;
                    push_data.found_position = hold_pos_k[pale_pkg::PosOutW-1:0];
                    push_data.entry_value    = hold_val_reg;
                end
                else
                begin
                    push_data.status = status_reg;
                end
                push = slot_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pale_pkg::S_IDLE;
            fill_reg       <= CW'(InitFill);
            pend_reg       <= 1'b0;
            rem_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= pale_pkg::KIND_INSERT;
            status_reg     <= pale_pkg::ST_OK;
            cap_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            pend_reg       <= pend_next;
            rem_reg        <= rem_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
            status_reg     <= status_next;
            cap_reg        <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        hold_pos_reg <= hold_pos_next;
        hold_val_reg <= hold_val_next;
        out_data_reg <= out_data_next;
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && rd_addr == wr_addr))
        else $error("read and write to the same entry");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> slot_free)
        else $error("result item overwritten");

    a_shift_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pale_pkg::S_SHIFT |=> $stable(fill_reg))
        else $error("fill count moved during shift");

endmodule
